// File: hw/rtl/frie_pkg.sv
// shared types and constants for the four-register instruction execute block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package frie_pkg;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 16;
  localparam int KIND_W = 4;
  localparam int REG_W  = 2;
  localparam int NREGS  = 4;
  localparam int STAT_W = 2;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int DCNT_W = $clog2(DATA_W);

  // raw instruction kind codes
  localparam logic [KIND_W-1:0] KIND_ADD  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_SUB  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_MUL  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_DIV  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_DEC  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_INC  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_LOAD = 4'd6;
  localparam logic [KIND_W-1:0] KIND_JUMP = 4'd7;
  localparam logic [KIND_W-1:0] KIND_JZ   = 4'd8;
  localparam logic [KIND_W-1:0] KIND_STOP = 4'd9;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd1;
  localparam logic [STAT_W-1:0] ST_DIVZERO = 2'd2;

  // register names
  localparam logic [REG_W-1:0] REG_AX = 2'd0;
  localparam logic [REG_W-1:0] REG_BX = 2'd1;
  localparam logic [REG_W-1:0] REG_CX = 2'd2;
  localparam logic [REG_W-1:0] REG_DX = 2'd3;

  typedef enum logic [3:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_DEC,
    OP_INC,
    OP_LOAD,
    OP_JUMP,
    OP_JZ,
    OP_STOP,
    OP_BAD
  } op_kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EXEC,
    B_DIV
  } back_state_t;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [REG_W-1:0]        dest_reg;
    logic                    source_is_register;
    logic [REG_W-1:0]        source_reg;
    logic signed [DATA_W-1:0] immediate;
    logic [ADDR_W-1:0]       target;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] written_value;
    logic                     jump_taken;
    logic [ADDR_W-1:0]        jump_address;
    logic                     stopped;
    logic [STAT_W-1:0]        status;
  } out_t;

  // classified instruction as it sits in the queue
  typedef struct packed {
    op_kind_t                 op;
    logic [REG_W-1:0]         dest;
    logic                     src_is_reg;
    logic [REG_W-1:0]         src;
    logic signed [DATA_W-1:0] imm;
    logic [ADDR_W-1:0]        target;
  } op_t;

  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] dividend;
    logic signed [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/frie_front.sv
// front end: accepts requests, classifies the kind, holds them in a short queue
// depends on frie_pkg
`timescale 1ns / 1ps
`default_nettype none

module frie_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire frie_pkg::in_t in_data,
  output logic               q_valid,
  output frie_pkg::op_t      q_op,
  input  wire logic          q_pop
);

  frie_pkg::op_t                   fifo_r [frie_pkg::QDEPTH];
  logic [frie_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [frie_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [frie_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  frie_pkg::op_t                   cls;
  logic                            push;
  logic                            pop;

  always_comb begin
    cls.dest       = in_data.dest_reg;
    cls.src_is_reg = in_data.source_is_register;
    cls.src        = in_data.source_reg;
    cls.imm        = in_data.immediate;
    cls.target     = in_data.target;
    case (in_data.kind)
      frie_pkg::KIND_ADD:  cls.op = frie_pkg::OP_ADD;
      frie_pkg::KIND_SUB:  cls.op = frie_pkg::OP_SUB;
      frie_pkg::KIND_MUL:  cls.op = frie_pkg::OP_MUL;
      frie_pkg::KIND_DIV:  cls.op = frie_pkg::OP_DIV;
      frie_pkg::KIND_DEC:  cls.op = frie_pkg::OP_DEC;
      frie_pkg::KIND_INC:  cls.op = frie_pkg::OP_INC;
      frie_pkg::KIND_LOAD: cls.op = frie_pkg::OP_LOAD;
      frie_pkg::KIND_JUMP: cls.op = frie_pkg::OP_JUMP;
      frie_pkg::KIND_JZ:   cls.op = frie_pkg::OP_JZ;
      frie_pkg::KIND_STOP: cls.op = frie_pkg::OP_STOP;
      default:             cls.op = frie_pkg::OP_BAD;
    endcase
  end

  assign in_ready = (cnt_r != frie_pkg::QCNT_W'(frie_pkg::QDEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_op     = fifo_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == frie_pkg::QPTR_W'(frie_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == frie_pkg::QPTR_W'(frie_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/frie_div.sv
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// depends on frie_pkg
`timescale 1ns / 1ps
`default_nettype none

module frie_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire frie_pkg::div_req_t req,
  output frie_pkg::div_rsp_t      rsp
);

  logic [frie_pkg::DATA_W-1:0] rem_r, rem_nxt;
  logic [frie_pkg::DATA_W-1:0] quo_r, quo_nxt;
  logic [frie_pkg::DATA_W-1:0] dvs_r;
  logic                        neg_r;
  logic                        busy_r;
  logic                        done_r;
  logic [frie_pkg::DCNT_W-1:0] cnt_r;
  logic [frie_pkg::DATA_W-1:0] rem_sh;
  logic [frie_pkg::DATA_W:0]   diff;
  logic                        ge;
  logic [frie_pkg::DATA_W-1:0] mag_a;
  logic [frie_pkg::DATA_W-1:0] mag_b;

  assign mag_a = req.dividend[frie_pkg::DATA_W-1] ? -req.dividend : req.dividend;
  assign mag_b = req.divisor[frie_pkg::DATA_W-1]  ? -req.divisor  : req.divisor;

  // restoring step: remainder stays below the divisor, so its top bit is free
  always_comb begin
    rem_sh  = {rem_r[frie_pkg::DATA_W-2:0], quo_r[frie_pkg::DATA_W-1]};
    diff    = {1'b0, rem_sh} - {1'b0, dvs_r};
    ge      = !diff[frie_pkg::DATA_W];
    rem_nxt = ge ? diff[frie_pkg::DATA_W-1:0] : rem_sh;
    quo_nxt = {quo_r[frie_pkg::DATA_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= frie_pkg::DCNT_W'(frie_pkg::DATA_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= mag_a;
      dvs_r <= mag_b;
      neg_r <= req.dividend[frie_pkg::DATA_W-1] ^ req.divisor[frie_pkg::DATA_W-1];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  // most negative over minus one wraps back to most negative here
  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? -quo_r : quo_r;

endmodule

`default_nettype wire

// File: hw/rtl/frie_back.sv
// back end: register file, execute unit, divider control and result register
// depends on frie_pkg and frie_div
`timescale 1ns / 1ps
`default_nettype none

module frie_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire frie_pkg::op_t q_op,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output frie_pkg::out_t     out_data
);

  frie_pkg::back_state_t       state_r, state_nxt;
  frie_pkg::op_t               op_r;
  logic [frie_pkg::DATA_W-1:0] mem [frie_pkg::NREGS];
  logic [frie_pkg::NREGS-1:0]  wvalid_r;
  logic [frie_pkg::DATA_W-1:0] cur_r;
  logic [frie_pkg::DATA_W-1:0] srd_r;
  logic [frie_pkg::DATA_W-1:0] src;
  logic                        out_valid_r;
  frie_pkg::out_t              out_data_r;
  logic                        out_free;
  logic                        wr_en;
  logic                        load_out;
  logic                        div_zero;
  frie_pkg::out_t              res;
  logic [frie_pkg::DATA_W-1:0] product;
  frie_pkg::div_req_t          dreq;
  frie_pkg::div_rsp_t          drsp;

  assign out_free = !out_valid_r || out_ready;
  assign src      = op_r.src_is_reg ? srd_r : op_r.imm;
  assign div_zero = (src == '0);
  assign product  = cur_r * src;

  frie_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  // result of the held instruction
  always_comb begin
    res.written_value = cur_r;
    res.jump_taken    = 1'b0;
    res.jump_address  = '0;
    res.stopped       = 1'b0;
    res.status        = frie_pkg::ST_OK;
    case (op_r.op)
      frie_pkg::OP_ADD:  res.written_value = cur_r + src;
      frie_pkg::OP_SUB:  res.written_value = cur_r - src;
      frie_pkg::OP_MUL:  res.written_value = product;
      frie_pkg::OP_DIV: begin
        if (div_zero) begin
          res.status = frie_pkg::ST_DIVZERO;
        end else begin
          res.written_value = drsp.quotient;
        end
      end
      frie_pkg::OP_DEC:  res.written_value = cur_r - 1'b1;
      frie_pkg::OP_INC:  res.written_value = cur_r + 1'b1;
      frie_pkg::OP_LOAD: res.written_value = src;
      frie_pkg::OP_JUMP: begin
        res.jump_taken   = 1'b1;
        res.jump_address = op_r.target;
      end
      frie_pkg::OP_JZ: begin
        if (cur_r == '0) begin
          res.jump_taken   = 1'b1;
          res.jump_address = op_r.target;
        end
      end
      frie_pkg::OP_STOP: res.stopped = 1'b1;
      default:           res.status  = frie_pkg::ST_UNKNOWN;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      frie_pkg::B_IDLE: begin
        if (q_valid) begin
          state_nxt = frie_pkg::B_EXEC;
        end
      end
      frie_pkg::B_EXEC: begin
        if (op_r.op == frie_pkg::OP_DIV && !div_zero) begin
          state_nxt = frie_pkg::B_DIV;
        end else if (out_free) begin
          state_nxt = frie_pkg::B_IDLE;
        end
      end
      frie_pkg::B_DIV: begin
        if (drsp.done && out_free) begin
          state_nxt = frie_pkg::B_IDLE;
        end
      end
      default: state_nxt = frie_pkg::B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    load_out      = 1'b0;
    dreq.start    = 1'b0;
    dreq.dividend = cur_r;
    dreq.divisor  = src;
    case (state_r)
      frie_pkg::B_IDLE: q_pop = q_valid;
      frie_pkg::B_EXEC: begin
        if (op_r.op == frie_pkg::OP_DIV && !div_zero) begin
          dreq.start = 1'b1;
        end else if (out_free) begin
          wr_en    = 1'b1;
          load_out = 1'b1;
        end
      end
      frie_pkg::B_DIV: begin
        if (drsp.done && out_free) begin
          wr_en    = 1'b1;
          load_out = 1'b1;
        end
      end
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frie_pkg::B_IDLE;
      wvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) begin
        wvalid_r[op_r.dest] <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // register file: one write port, two registered read ports, never-written reads as zero
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[op_r.dest] <= res.written_value;
    end
    if (q_pop) begin
      op_r  <= q_op;
      cur_r <= wvalid_r[q_op.dest] ? mem[q_op.dest] : '0;
      srd_r <= wvalid_r[q_op.src]  ? mem[q_op.src]  : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: hw/rtl/four_register_instruction_execute.sv
// top level of the four-register instruction execute block
// depends on frie_pkg, frie_front and frie_back
`timescale 1ns / 1ps
`default_nettype none

// Executes decoded instructions on four 32-bit signed registers (AX, BX, CX,
// DX), reset to zero, and returns one result per instruction in order. A
// two-entry queue sits between the input side and the execute side, and a
// result register sits on the output, so a new request is taken while a
// finished result waits. Inside the execute side an instruction goes
// through register read, then execute and write back; a divide with a
// nonzero divisor also waits for the one-bit-per-cycle divider before
// write back. Add, subtract and multiply wrap at 32 bits, divide truncates
// toward zero, a divide by zero leaves the register unchanged with status 2,
// and an unknown kind reports status 1.
module four_register_instruction_execute (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire frie_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output frie_pkg::out_t      out_data
);

  logic          q_valid;
  frie_pkg::op_t q_op;
  logic          q_pop;

  frie_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_pop   (q_pop)
  );

  frie_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_op     (q_op),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// File: tb/frie_exec_checker.sv
`timescale 1ns / 1ps
// checker for the four-register instruction execute block: predicts and compares results
// depends on frie_pkg

module frie_exec_checker (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_ready,
  input  wire frie_pkg::in_t  in_data,
  input  wire logic           out_valid,
  input  wire logic           out_ready,
  input  wire frie_pkg::out_t out_data,
  output int                  fail_count,
  output int                  pending,
  output int                  checked
);

  logic [frie_pkg::DATA_W-1:0] regs [frie_pkg::NREGS];
  frie_pkg::out_t              pending_results[$];

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  // executes one request on the shadow register file
  function automatic frie_pkg::out_t exec_instr(input frie_pkg::in_t ins);
    logic [frie_pkg::DATA_W-1:0] src;
    logic [frie_pkg::DATA_W-1:0] cur;
    logic [frie_pkg::DATA_W-1:0] res;
    logic [frie_pkg::DATA_W-1:0] mag_a;
    logic [frie_pkg::DATA_W-1:0] mag_b;
    logic [frie_pkg::DATA_W-1:0] quo;
    frie_pkg::out_t r;
    src = ins.source_is_register ? regs[ins.source_reg] : ins.immediate;
    cur = regs[ins.dest_reg];
    res = cur;
    r = '0;
    r.status = frie_pkg::ST_OK;
    case (ins.kind)
      frie_pkg::KIND_ADD:  res = cur + src;
      frie_pkg::KIND_SUB:  res = cur - src;
      frie_pkg::KIND_MUL:  res = cur * src;
      frie_pkg::KIND_DIV: begin
        if (src == '0) begin
          r.status = frie_pkg::ST_DIVZERO;
        end else begin
          // unsigned magnitudes so the most negative value divides cleanly
          mag_a = cur[frie_pkg::DATA_W-1] ? -cur : cur;
          mag_b = src[frie_pkg::DATA_W-1] ? -src : src;
          quo = mag_a / mag_b;
          res = (cur[frie_pkg::DATA_W-1] ^ src[frie_pkg::DATA_W-1]) ? -quo : quo;
        end
      end
      frie_pkg::KIND_DEC:  res = cur - 1'b1;
      frie_pkg::KIND_INC:  res = cur + 1'b1;
      frie_pkg::KIND_LOAD: res = src;
      frie_pkg::KIND_JUMP: begin
        r.jump_taken = 1'b1;
        r.jump_address = ins.target;
      end
      frie_pkg::KIND_JZ: begin
        if (cur == '0) begin
          r.jump_taken = 1'b1;
          r.jump_address = ins.target;
        end
      end
      frie_pkg::KIND_STOP: r.stopped = 1'b1;
      default:             r.status = frie_pkg::ST_UNKNOWN;
    endcase
    regs[ins.dest_reg] = res;
    r.written_value = res;
    return r;
  endfunction

  always @(posedge clk) begin
    frie_pkg::out_t exp_res;
    if (!rst_n) begin
      for (int i = 0; i < frie_pkg::NREGS; i++) regs[i] = '0;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with no request pending: %h", out_data));
        end else begin
          exp_res = pending_results.pop_front();
          checked <= checked + 1;
          if (out_data.written_value !== exp_res.written_value)
            report_mismatch($sformatf("written_value got %0d expected %0d",
                                      out_data.written_value, exp_res.written_value));
          if (out_data.jump_taken !== exp_res.jump_taken)
            report_mismatch($sformatf("jump_taken got %b expected %b",
                                      out_data.jump_taken, exp_res.jump_taken));
          if (out_data.jump_address !== exp_res.jump_address)
            report_mismatch($sformatf("jump_address got %h expected %h",
                                      out_data.jump_address, exp_res.jump_address));
          if (out_data.stopped !== exp_res.stopped)
            report_mismatch($sformatf("stopped got %b expected %b",
                                      out_data.stopped, exp_res.stopped));
          if (out_data.status !== exp_res.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      out_data.status, exp_res.status));
        end
      end
      if (in_valid && in_ready) pending_results = {pending_results, exec_instr(in_data)};
    end
    pending <= pending_results.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// top of the testbench for four_register_instruction_execute: clock, reset, stimulus, verdict
// depends on frie_pkg, the block and frie_exec_checker

module tb;

  localparam logic [frie_pkg::KIND_W-1:0] KIND_BAD_LO = 4'd10;
  localparam logic [frie_pkg::KIND_W-1:0] KIND_BAD_HI = 4'd15;
  localparam logic [frie_pkg::DATA_W-1:0] DATA_MAX = {1'b0, {(frie_pkg::DATA_W-1){1'b1}}};
  localparam logic [frie_pkg::DATA_W-1:0] DATA_MIN = {1'b1, {(frie_pkg::DATA_W-1){1'b0}}};
  localparam int RANDOM_ITEMS = 1025;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 60;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  frie_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  frie_pkg::out_t out_data;

  int fail_count;
  int pending;
  int checked;
  int issued = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;

  four_register_instruction_execute dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  frie_exec_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // result side: random back-pressure, always ready while steady, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 34);
      end
    end
  end

  function automatic frie_pkg::in_t make_instr(input logic [frie_pkg::KIND_W-1:0] kind,
                                               input logic [frie_pkg::REG_W-1:0] dst,
                                               input logic use_reg,
                                               input logic [frie_pkg::REG_W-1:0] sreg,
                                               input logic [frie_pkg::DATA_W-1:0] imm,
                                               input logic [frie_pkg::ADDR_W-1:0] tgt);
    frie_pkg::in_t r;
    r.kind = kind;
    r.dest_reg = dst;
    r.source_is_register = use_reg;
    r.source_reg = sreg;
    r.immediate = imm;
    r.target = tgt;
    return r;
  endfunction

  // operands lean toward zero, one and the extremes
  function automatic logic [frie_pkg::DATA_W-1:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return $urandom_range(0, 1) ? 32'd1 : -32'sd1;
      2: return $urandom_range(0, 1) ? DATA_MAX : DATA_MIN;
      3: return $urandom_range(0, 16) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic frie_pkg::in_t rand_instr();
    logic [frie_pkg::KIND_W-1:0] kind;
    if ($urandom_range(0, 99) < 8)
      kind = frie_pkg::KIND_W'($urandom_range(KIND_BAD_LO, KIND_BAD_HI));
    else if ($urandom_range(0, 99) < 20) kind = frie_pkg::KIND_LOAD;
    else kind = frie_pkg::KIND_W'($urandom_range(frie_pkg::KIND_ADD, frie_pkg::KIND_STOP));
    return make_instr(kind, frie_pkg::REG_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      frie_pkg::REG_W'($urandom_range(0, 3)), rand_operand(),
                      frie_pkg::ADDR_W'($urandom));
  endfunction

  task automatic send_instr(input frie_pkg::in_t item);
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    issued++;
    if (!steady) begin
      while ($urandom_range(0, 99) < 34) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_instr(make_instr(frie_pkg::KIND_LOAD, frie_pkg::REG_AX, 1'b0, frie_pkg::REG_AX,
                          DATA_MAX, 16'h0000));
    send_instr(make_instr(frie_pkg::KIND_ADD, frie_pkg::REG_AX, 1'b0, frie_pkg::REG_BX,
                          32'd1, 16'hffff));
    send_instr(make_instr(frie_pkg::KIND_LOAD, frie_pkg::REG_BX, 1'b0, frie_pkg::REG_CX,
                          -32'sd1, 16'h0000));
    // most negative over minus one wraps
    send_instr(make_instr(frie_pkg::KIND_DIV, frie_pkg::REG_AX, 1'b1, frie_pkg::REG_BX,
                          32'd0, 16'h0000));
    send_instr(make_instr(frie_pkg::KIND_LOAD, frie_pkg::REG_CX, 1'b0, frie_pkg::REG_AX,
                          32'd0, 16'h0000));
    send_instr(make_instr(frie_pkg::KIND_DIV, frie_pkg::REG_AX, 1'b1, frie_pkg::REG_CX,
                          32'd5, 16'h0000));
    send_instr(make_instr(frie_pkg::KIND_DIV, frie_pkg::REG_BX, 1'b0, frie_pkg::REG_DX,
                          32'd0, 16'h0000));
    send_instr(make_instr(frie_pkg::KIND_LOAD, frie_pkg::REG_DX, 1'b0, frie_pkg::REG_AX,
                          -32'sd7, 16'h0000));
    send_instr(make_instr(frie_pkg::KIND_DIV, frie_pkg::REG_DX, 1'b0, frie_pkg::REG_AX,
                          32'd2, 16'h0000));
    send_instr(make_instr(frie_pkg::KIND_MUL, frie_pkg::REG_AX, 1'b1, frie_pkg::REG_BX,
                          32'd0, 16'h0000));
    send_instr(make_instr(frie_pkg::KIND_SUB, frie_pkg::REG_CX, 1'b0, frie_pkg::REG_AX,
                          DATA_MIN, 16'h0000));
    send_instr(make_instr(frie_pkg::KIND_DEC, frie_pkg::REG_CX, 1'b0, frie_pkg::REG_AX,
                          DATA_MAX, 16'hffff));
    send_instr(make_instr(frie_pkg::KIND_INC, frie_pkg::REG_CX, 1'b1, frie_pkg::REG_DX,
                          DATA_MIN, 16'hffff));
    send_instr(make_instr(frie_pkg::KIND_MUL, frie_pkg::REG_DX, 1'b0, frie_pkg::REG_AX,
                          DATA_MAX, 16'h0000));
    send_instr(make_instr(frie_pkg::KIND_JUMP, frie_pkg::REG_DX, 1'b0, frie_pkg::REG_AX,
                          32'd0, 16'hffff));
    send_instr(make_instr(frie_pkg::KIND_JZ, frie_pkg::REG_AX, 1'b0, frie_pkg::REG_AX,
                          32'd0, 16'h1234));
    send_instr(make_instr(frie_pkg::KIND_LOAD, frie_pkg::REG_AX, 1'b0, frie_pkg::REG_AX,
                          32'd0, 16'h0000));
    send_instr(make_instr(frie_pkg::KIND_JZ, frie_pkg::REG_AX, 1'b1, frie_pkg::REG_DX,
                          DATA_MAX, 16'hffff));
    send_instr(make_instr(frie_pkg::KIND_STOP, frie_pkg::REG_BX, 1'b1, frie_pkg::REG_CX,
                          DATA_MIN, 16'habcd));
    send_instr(make_instr(KIND_BAD_LO, frie_pkg::REG_CX, 1'b0, frie_pkg::REG_AX,
                          32'd9, 16'h5555));
    send_instr(make_instr(KIND_BAD_HI, frie_pkg::REG_DX, 1'b1, frie_pkg::REG_BX,
                          DATA_MAX, 16'hffff));
    send_instr(make_instr(frie_pkg::KIND_ADD, frie_pkg::REG_DX, 1'b1, frie_pkg::REG_DX,
                          32'd0, 16'h0000));
    send_instr(make_instr(frie_pkg::KIND_LOAD, frie_pkg::REG_BX, 1'b1, frie_pkg::REG_DX,
                          32'd0, 16'h0000));
    send_instr(make_instr(frie_pkg::KIND_DIV, frie_pkg::REG_CX, 1'b0, frie_pkg::REG_AX,
                          -32'sd1, 16'h0000));
    send_instr(make_instr(frie_pkg::KIND_DIV, frie_pkg::REG_DX, 1'b0, frie_pkg::REG_AX,
                          DATA_MIN, 16'h0000));
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // stall the result side long enough to back up the queue
      if (i == 300) hold_req = 1'b1;
      if (i == 600) wait_drained();
      steady = (i >= 700 && i < 850);
      send_instr(rand_instr());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("issued %0d instructions, compared %0d results", issued, checked);
    $display("covered overflow, divide by zero, jumps, stop, unknown kinds and a %0d-cycle stall",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/frie_pkg.sv
hw/rtl/frie_front.sv
hw/rtl/frie_div.sv
hw/rtl/frie_back.sv
hw/rtl/four_register_instruction_execute.sv
tb/frie_exec_checker.sv
tb/tb.sv
